// ===== design/gcd_pkg.sv =====
// ---------------------------------------------------------------------------
// gcd_pkg: shared constants for the great-circle distance pipeline
// Fixed-point formats, reduction bounds, the degree-to-radian factor and the
// CORDIC arctangent table used by the rotation and vectoring units.
// ---------------------------------------------------------------------------
package gcd_pkg;

    // Angle in degrees with 17 fraction bits, as fed to a rotation unit.
    localparam int ANG_W = 26;

    // Reduction bounds in degrees, 17 fraction bits.
    localparam logic signed [26:0] TURN_D17    = 27'sd47185920;
    localparam logic signed [26:0] HALF_D17    = 27'sd23592960;
    localparam logic signed [26:0] QUARTER_D17 = 27'sd11796480;

    // Degrees (17 fraction bits) to radians (30 fraction bits), scaled by 2^28.
    // The 36-bit factor is split into two 18-bit halves for the multipliers.
    localparam logic [35:0] DEG_TO_RAD_K = 36'd38380196138;
    localparam logic [17:0] K_HI = DEG_TO_RAD_K[35:18];
    localparam logic [17:0] K_LO = DEG_TO_RAD_K[17:0];

    // CORDIC datapath widths and start value.
    localparam int XY_W = 33;
    localparam int Z_W  = 34;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN_INV = 33'sd652032874;
    localparam int MAX_STAGES = 32;

    // atan(2^-i) in radians with 30 fraction bits, truncated.
    localparam logic [29:0] ATAN_TAB [MAX_STAGES] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127,
        30'd63,        30'd31,        30'd15,        30'd7,
        30'd3,         30'd1,         30'd0,         30'd0
    };

    // One in Q30 and the square root unit size (one root bit per step).
    localparam logic [30:0] ONE_Q30    = 31'd1073741824;
    localparam int          SQRT_STEPS = 31;

    // Fixed latencies outside the CORDIC units.
    localparam int PREP_STAGES = 3;
    localparam int MUL_STAGES  = 3;
    localparam int DIST_STAGES = 2;

    // Radius register and result.
    localparam int               RADIUS_W     = 13;
    localparam logic [12:0]      RADIUS_RESET = 13'd6371;
    localparam int               DIST_W       = 23;
    localparam logic [22:0]      DIST_MAX     = 23'h7FFFFF;

endpackage

// ===== design/great_circle_distance.sv =====
// ---------------------------------------------------------------------------
// great_circle_distance: haversine distance between two points on a sphere
// Fully pipelined fixed-point haversine with CORDIC trigonometry.
// ---------------------------------------------------------------------------
// This block takes a pair of points, each as latitude and longitude in signed
// degrees with 16 fraction bits, and returns the great-circle distance between
// them in units of 1/256 km, saturating at the top of the 23-bit field. The
// radius is a 13-bit register in whole kilometers that resets to 6371. The
// user must write it through cfg_write and cfg_data only while no request is
// in flight; the block does not enforce this. A new request can be taken in
// every clock cycle in which in_stall is low. Each request passes through
// angle reduction and radian conversion, CORDIC_STAGES rotation steps that
// give the sines and cosines, the multiplies that form the haversine term,
// bit-serial-per-stage square roots, CORDIC_STAGES vectoring steps for the
// arctangent and the scaling by the radius. The whole pipeline moves
// together: when a finished result is held by out_stall, in_stall rises in
// the same cycle and nothing advances; empty slots do not collapse.
// ---------------------------------------------------------------------------
module great_circle_distance #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [gcd_pkg::RADIUS_W-1:0]          cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [23:0]                    first_latitude,
    input  logic signed [24:0]                    first_longitude,
    input  logic signed [23:0]                    second_latitude,
    input  logic signed [24:0]                    second_longitude,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [gcd_pkg::DIST_W-1:0]            arc_distance
);

    // Stages past 32 would only rotate by zero, so the units are capped there.
    localparam int NS  = (CORDIC_STAGES > gcd_pkg::MAX_STAGES) ?
                         gcd_pkg::MAX_STAGES : CORDIC_STAGES;
    localparam int LAT = gcd_pkg::PREP_STAGES + NS + gcd_pkg::MUL_STAGES +
                         gcd_pkg::SQRT_STEPS + NS + gcd_pkg::DIST_STAGES;
    localparam int XW  = gcd_pkg::XY_W;

    // The pipeline advances unless a finished result is waiting to be taken.
    logic adv;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    assign adv      = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !adv;
    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    assign out_valid = vld_reg[LAT-1];

    // Sphere radius register.
    logic [gcd_pkg::RADIUS_W-1:0] radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= gcd_pkg::RADIUS_RESET;
        end
        else if (cfg_write)
        begin
            radius_reg <= cfg_data;
        end
    end

    // Angles in degrees with 17 fraction bits. A plain difference of the
    // 16-fraction-bit inputs read with 17 fraction bits is the half angle,
    // and the latitudes are doubled to reach the same scale.
    logic signed [gcd_pkg::ANG_W-1:0] dlat_half;
    logic signed [gcd_pkg::ANG_W-1:0] dlon_half;
    logic signed [gcd_pkg::ANG_W-1:0] lat1_d17;
    logic signed [gcd_pkg::ANG_W-1:0] lat2_d17;

    always_comb
    begin
        dlat_half = 26'(second_latitude) - 26'(first_latitude);
        dlon_half = 26'(second_longitude) - 26'(first_longitude);
        lat1_d17  = {first_latitude[23], first_latitude, 1'b0};
        lat2_d17  = {second_latitude[23], second_latitude, 1'b0};
    end

    logic signed [XW-1:0] s_dlat;
    logic signed [XW-1:0] s_dlon;
    logic signed [XW-1:0] c_lat1;
    logic signed [XW-1:0] c_lat2;

    gcd_rot #(.STAGES(NS)) u_rot_dlat (
        .clk     (clk),
        .adv     (adv),
        .angle   (dlat_half),
        .sin_val (s_dlat),
        .cos_val ()
    );

    gcd_rot #(.STAGES(NS)) u_rot_dlon (
        .clk     (clk),
        .adv     (adv),
        .angle   (dlon_half),
        .sin_val (s_dlon),
        .cos_val ()
    );

    gcd_rot #(.STAGES(NS)) u_rot_lat1 (
        .clk     (clk),
        .adv     (adv),
        .angle   (lat1_d17),
        .sin_val (),
        .cos_val (c_lat1)
    );

    gcd_rot #(.STAGES(NS)) u_rot_lat2 (
        .clk     (clk),
        .adv     (adv),
        .angle   (lat2_d17),
        .sin_val (),
        .cos_val (c_lat2)
    );

    // First multiply cycle: both squared sines and the cosine product.
    logic signed [65:0] sq_lat_full;
    logic signed [65:0] sq_lon_full;
    logic signed [65:0] cc_full;
    logic [30:0]        sdlat2_reg;
    logic [30:0]        sdlon2_reg;
    logic signed [31:0] p_reg;

    // Second multiply cycle: the cosine product times the longitude term.
    logic signed [63:0] q_full;
    logic [30:0]        sdlat2_d_reg;
    logic signed [31:0] q_reg;

    // Third cycle: sum, clamp to [0,1] and the complement.
    logic signed [32:0] a_sum;
    logic [30:0]        a_clamp;
    logic [30:0]        a_reg;
    logic [30:0]        b_reg;

    always_comb
    begin
        sq_lat_full = s_dlat * s_dlat;
        sq_lon_full = s_dlon * s_dlon;
        cc_full     = c_lat1 * c_lat2;
        q_full      = p_reg * $signed({1'b0, sdlon2_reg});
        a_sum       = $signed({2'b00, sdlat2_d_reg}) + 33'(q_reg);
        if (a_sum < 0)
        begin
            a_clamp = '0;
        end
        else if (a_sum > $signed({2'b00, gcd_pkg::ONE_Q30}))
        begin
            a_clamp = gcd_pkg::ONE_Q30;
        end
        else
        begin
            a_clamp = a_sum[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sdlat2_reg   <= sq_lat_full[60:30];
            sdlon2_reg   <= sq_lon_full[60:30];
            p_reg        <= cc_full[61:30];
            sdlat2_d_reg <= sdlat2_reg;
            q_reg        <= q_full[61:30];
            a_reg        <= a_clamp;
            b_reg        <= gcd_pkg::ONE_Q30 - a_clamp;
        end
    end

    // Square roots of a and 1-a, then the arctangent of their ratio.
    logic [30:0] ys;
    logic [30:0] xs;
    logic [30:0] half_arc;

    gcd_sqrt u_sqrt_a (
        .clk  (clk),
        .adv  (adv),
        .val  (a_reg),
        .root (ys)
    );

    gcd_sqrt u_sqrt_b (
        .clk  (clk),
        .adv  (adv),
        .val  (b_reg),
        .root (xs)
    );

    gcd_vec #(.STAGES(NS)) u_vec (
        .clk   (clk),
        .adv   (adv),
        .xs    (xs),
        .ys    (ys),
        .angle (half_arc)
    );

    // Scale by the radius: R * 2z * 256 / 2^30, rounded, then saturated.
    logic [43:0] dprod_next;
    logic [43:0] dprod_reg;
    logic [44:0] dround;
    logic [23:0] dscaled;
    logic [gcd_pkg::DIST_W-1:0] dist_next;
    logic [gcd_pkg::DIST_W-1:0] dist_reg;

    always_comb
    begin
        dprod_next = radius_reg * half_arc;
        dround     = 45'(dprod_reg) + 45'd1048576;
        dscaled    = dround[44:21];
        dist_next  = dscaled[23] ? gcd_pkg::DIST_MAX : dscaled[22:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dprod_reg <= dprod_next;
            dist_reg  <= dist_next;
        end
    end

    assign arc_distance = dist_reg;

endmodule

// ===== design/gcd_rot.sv =====
// ---------------------------------------------------------------------------
// gcd_rot: pipelined sine and cosine of an angle in degrees
// Reduces the angle to a quarter turn, converts it to radians and runs one
// CORDIC rotation step per register stage.
// ---------------------------------------------------------------------------
module gcd_rot #(
    parameter int STAGES = 24
) (
    input  logic                               clk,
    input  logic                               adv,
    input  logic signed [gcd_pkg::ANG_W-1:0]   angle,
    output logic signed [gcd_pkg::XY_W-1:0]    sin_val,
    output logic signed [gcd_pkg::XY_W-1:0]    cos_val
);

    localparam int XW = gcd_pkg::XY_W;
    localparam int ZW = gcd_pkg::Z_W;

    // Stage one: reduce to [-180,180) and fold into [-90,90].
    logic signed [26:0] ang_ext;
    logic signed [26:0] red;
    logic signed [26:0] fold;
    logic               fold_neg;
    logic signed [24:0] fold_reg;
    logic               neg1_reg;

    always_comb
    begin
        ang_ext  = {angle[gcd_pkg::ANG_W-1], angle};
        if (ang_ext >= gcd_pkg::HALF_D17)
        begin
            red = ang_ext - gcd_pkg::TURN_D17;
        end
        else if (ang_ext < -gcd_pkg::HALF_D17)
        begin
            red = ang_ext + gcd_pkg::TURN_D17;
        end
        else
        begin
            red = ang_ext;
        end
        fold     = red;
        fold_neg = 1'b0;
        if (red > gcd_pkg::QUARTER_D17)
        begin
            fold     = gcd_pkg::HALF_D17 - red;
            fold_neg = 1'b1;
        end
        else if (red < -gcd_pkg::QUARTER_D17)
        begin
            fold     = -gcd_pkg::HALF_D17 - red;
            fold_neg = 1'b1;
        end
    end

    // Stage two: magnitude times the split conversion factor.
    logic [24:0] mag_full;
    logic [23:0] mag;
    logic [41:0] ph_next;
    logic [41:0] pl_next;
    logic [41:0] ph_reg;
    logic [41:0] pl_reg;
    logic        sgn2_reg;
    logic        neg2_reg;

    always_comb
    begin
        mag_full = fold_reg[24] ? 25'(-fold_reg) : 25'(fold_reg);
        mag      = mag_full[23:0];
        ph_next  = mag * gcd_pkg::K_HI;
        pl_next  = mag * gcd_pkg::K_LO;
    end

    // Stage three: combine, round and apply the sign.
    logic [59:0]          rad_sum;
    logic [31:0]          rad_mag;
    logic signed [ZW-1:0] z0_next;
    logic signed [ZW-1:0] z0_reg;
    logic                 neg3_reg;

    always_comb
    begin
        rad_sum = {ph_reg, 18'd0} + 60'(pl_reg) + 60'd134217728;
        rad_mag = rad_sum[59:28];
        z0_next = sgn2_reg ? -$signed({2'b00, rad_mag}) : $signed({2'b00, rad_mag});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fold_reg <= fold[24:0];
            neg1_reg <= fold_neg;
            ph_reg   <= ph_next;
            pl_reg   <= pl_next;
            sgn2_reg <= fold_reg[24];
            neg2_reg <= neg1_reg;
            z0_reg   <= z0_next;
            neg3_reg <= neg2_reg;
        end
    end

    // CORDIC rotation, one step per stage.
    logic signed [XW-1:0] x_reg    [STAGES];
    logic signed [XW-1:0] y_reg    [STAGES];
    logic signed [ZW-1:0] z_reg    [STAGES];
    logic                 neg_reg  [STAGES];
    logic signed [XW-1:0] x_next   [STAGES];
    logic signed [XW-1:0] y_next   [STAGES];
    logic signed [ZW-1:0] z_next   [STAGES];
    logic                 neg_next [STAGES];

    always_comb
    begin
        logic signed [XW-1:0] xi;
        logic signed [XW-1:0] yi;
        logic signed [ZW-1:0] zi;
        logic signed [ZW-1:0] at;
        for (int i = 0; i < STAGES; i++)
        begin
            if (i == 0)
            begin
                xi          = gcd_pkg::CORDIC_GAIN_INV;
                yi          = '0;
                zi          = z0_reg;
                neg_next[i] = neg3_reg;
            end
            else
            begin
                xi          = x_reg[i-1];
                yi          = y_reg[i-1];
                zi          = z_reg[i-1];
                neg_next[i] = neg_reg[i-1];
            end
            at = $signed({4'd0, gcd_pkg::ATAN_TAB[i]});
            if (zi >= 0)
            begin
                x_next[i] = xi - (yi >>> i);
                y_next[i] = yi + (xi >>> i);
                z_next[i] = zi - at;
            end
            else
            begin
                x_next[i] = xi + (yi >>> i);
                y_next[i] = yi - (xi >>> i);
                z_next[i] = zi + at;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                x_reg[i]   <= x_next[i];
                y_reg[i]   <= y_next[i];
                z_reg[i]   <= z_next[i];
                neg_reg[i] <= neg_next[i];
            end
        end
    end

    assign sin_val = y_reg[STAGES-1];
    assign cos_val = neg_reg[STAGES-1] ? -x_reg[STAGES-1] : x_reg[STAGES-1];

endmodule

// ===== design/gcd_sqrt.sv =====
// ---------------------------------------------------------------------------
// gcd_sqrt: pipelined floor square root of a Q30 value shifted up by 30
// Restoring digit-by-digit root, one result bit per register stage.
// ---------------------------------------------------------------------------
module gcd_sqrt (
    input  logic        clk,
    input  logic        adv,
    input  logic [30:0] val,
    output logic [30:0] root
);

    localparam int N   = gcd_pkg::SQRT_STEPS;
    localparam int RW  = 34;

    logic [RW-1:0] rem_reg   [N];
    logic [30:0]   root_reg  [N];
    logic [61:0]   rad_reg   [N];
    logic [RW-1:0] rem_next  [N];
    logic [30:0]   root_next [N];
    logic [61:0]   rad_next  [N];

    always_comb
    begin
        logic [RW-1:0] rp;
        logic [30:0]   qp;
        logic [61:0]   vp;
        logic [RW-1:0] sh;
        logic [RW-1:0] trial;
        for (int k = 0; k < N; k++)
        begin
            if (k == 0)
            begin
                rp = '0;
                qp = '0;
                vp = {1'b0, val, 30'd0};
            end
            else
            begin
                rp = rem_reg[k-1];
                qp = root_reg[k-1];
                vp = rad_reg[k-1];
            end
            sh          = {rp[RW-3:0], vp[61:60]};
            trial       = {1'b0, qp, 2'b01};
            rad_next[k] = {vp[59:0], 2'b00};
            if (sh >= trial)
            begin
                rem_next[k]  = sh - trial;
                root_next[k] = {qp[29:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = sh;
                root_next[k] = {qp[29:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < N; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_next[k];
            end
        end
    end

    assign root = root_reg[N-1];

endmodule

// ===== design/gcd_vec.sv =====
// ---------------------------------------------------------------------------
// gcd_vec: pipelined CORDIC arctangent of a first-quadrant vector
// One vectoring step per register stage; a negative angle reads as zero.
// ---------------------------------------------------------------------------
module gcd_vec #(
    parameter int STAGES = 24
) (
    input  logic        clk,
    input  logic        adv,
    input  logic [30:0] xs,
    input  logic [30:0] ys,
    output logic [30:0] angle
);

    localparam int XW = gcd_pkg::XY_W;
    localparam int ZW = gcd_pkg::Z_W;

    logic signed [XW-1:0] x_reg  [STAGES];
    logic signed [XW-1:0] y_reg  [STAGES];
    logic signed [ZW-1:0] z_reg  [STAGES];
    logic signed [XW-1:0] x_next [STAGES];
    logic signed [XW-1:0] y_next [STAGES];
    logic signed [ZW-1:0] z_next [STAGES];

    always_comb
    begin
        logic signed [XW-1:0] xi;
        logic signed [XW-1:0] yi;
        logic signed [ZW-1:0] zi;
        logic signed [ZW-1:0] at;
        for (int i = 0; i < STAGES; i++)
        begin
            if (i == 0)
            begin
                xi = $signed({2'b00, xs});
                yi = $signed({2'b00, ys});
                zi = '0;
            end
            else
            begin
                xi = x_reg[i-1];
                yi = y_reg[i-1];
                zi = z_reg[i-1];
            end
            at = $signed({4'd0, gcd_pkg::ATAN_TAB[i]});
            if (yi >= 0)
            begin
                x_next[i] = xi + (yi >>> i);
                y_next[i] = yi - (xi >>> i);
                z_next[i] = zi + at;
            end
            else
            begin
                x_next[i] = xi - (yi >>> i);
                y_next[i] = yi + (xi >>> i);
                z_next[i] = zi - at;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
            end
        end
    end

    assign angle = z_reg[STAGES-1][ZW-1] ? '0 : z_reg[STAGES-1][30:0];

endmodule

// ===== dv/great_circle_distance_tb.sv =====
// ---------------------------------------------------------------------------
// great_circle_distance_tb: self-checking bench for the haversine pipeline
// Drives point pairs with bursty valid and a patterned output stall, predicts
// each distance in fixed point and compares results in request order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module great_circle_distance_tb;

    localparam int STAGES     = 24;
    localparam int PIPE_DEPTH = 2 * STAGES + 39;
    localparam int CYCLE_LIMIT = 400000;

    // Distance predictor and the store of distances still owed by the block.
    class distance_scoreboard;
        longint       radius_km;
        longint       expected_dist[$];
        int           errors;

        function new();
            radius_km = longint'(gcd_pkg::RADIUS_RESET);
            errors    = 0;
        endfunction

        // Rotation mode CORDIC: degrees with 17 fraction bits to sine and
        // cosine in Q30, after folding the angle into [-90, 90].
        function automatic void sin_cos(input longint deg, output longint s,
                                        output longint c);
            longint               r, rad, x, y, nx;
            longint unsigned      mag;
            bit                   neg_cos;
            r = deg % longint'(gcd_pkg::TURN_D17);
            neg_cos = 0;
            if (r < 0)
                r += longint'(gcd_pkg::TURN_D17);
            if (r >= longint'(gcd_pkg::HALF_D17))
                r -= longint'(gcd_pkg::TURN_D17);
            if (r > longint'(gcd_pkg::QUARTER_D17))
            begin
                r = longint'(gcd_pkg::HALF_D17) - r;
                neg_cos = 1;
            end
            else if (r < -longint'(gcd_pkg::QUARTER_D17))
            begin
                r = -longint'(gcd_pkg::HALF_D17) - r;
                neg_cos = 1;
            end
            mag = (r < 0) ? -r : r;
            rad = longint'((mag * 64'd38380196138 + (64'd1 << 27)) >> 28);
            if (r < 0)
                rad = -rad;
            x = longint'(gcd_pkg::CORDIC_GAIN_INV);
            y = 0;
            for (int i = 0; i < STAGES && i < 32; i++)
            begin
                if (rad >= 0)
                begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    rad -= longint'(gcd_pkg::ATAN_TAB[i]);
                end
                else
                begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    rad += longint'(gcd_pkg::ATAN_TAB[i]);
                end
                x = nx;
            end
            s = y;
            c = neg_cos ? -x : x;
        endfunction

        function automatic longint unsigned floor_root(input longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        // Vectoring mode CORDIC: half the central angle in radians, Q30.
        function automatic longint central_angle(input longint x, input longint y);
            longint z, nx;
            z = 0;
            for (int i = 0; i < STAGES && i < 32; i++)
            begin
                if (y >= 0)
                begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z += longint'(gcd_pkg::ATAN_TAB[i]);
                end
                else
                begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z -= longint'(gcd_pkg::ATAN_TAB[i]);
                end
                x = nx;
            end
            return (z < 0) ? 0 : z;
        endfunction

        // An accepted request: work out its distance and queue it.
        function void note_request(input logic signed [23:0] lat_a,
                                   input logic signed [24:0] lon_a,
                                   input logic signed [23:0] lat_b,
                                   input logic signed [24:0] lon_b);
            longint s_dlat, s_dlon, c1, c2, unused, sdlat2, sdlon2, p, q, a, z, d;
            longint one;
            one = longint'(gcd_pkg::ONE_Q30);
            // The half difference of a 16-fraction-bit pair is the plain
            // difference read with 17 fraction bits.
            sin_cos(longint'(lat_b) - longint'(lat_a), s_dlat, unused);
            sin_cos(longint'(lon_b) - longint'(lon_a), s_dlon, unused);
            sin_cos(longint'(lat_a) * 2, unused, c1);
            sin_cos(longint'(lat_b) * 2, unused, c2);
            sdlat2 = (s_dlat * s_dlat) >>> 30;
            sdlon2 = (s_dlon * s_dlon) >>> 30;
            p = (c1 * c2) >>> 30;
            q = (p * sdlon2) >>> 30;
            a = sdlat2 + q;
            if (a < 0)
                a = 0;
            if (a > one)
                a = one;
            z = central_angle(longint'(floor_root(longint'(one - a) << 30)),
                              longint'(floor_root(a << 30)));
            d = (radius_km * z + (64'sd1 << 20)) >>> 21;
            if (d > longint'(gcd_pkg::DIST_MAX))
                d = longint'(gcd_pkg::DIST_MAX);
            expected_dist.push_back(d);
        endfunction

        task report(input string what);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        task check_distance(input logic [22:0] got);
            longint want;
            if (expected_dist.size() == 0)
                report($sformatf("distance %0d with no request pending", got));
            else
            begin
                want = expected_dist.pop_front();
                if (longint'(got) != want)
                    report($sformatf("arc_distance %0d, expected %0d", got, want));
            end
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_write;
    logic [12:0]         cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic signed [23:0]  first_latitude;
    logic signed [24:0]  first_longitude;
    logic signed [23:0]  second_latitude;
    logic signed [24:0]  second_longitude;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [22:0]         arc_distance;

    distance_scoreboard  board;
    int                  cycle_count = 0;
    int                  accepted = 0;
    bit                  hold_started = 1'b0;

    great_circle_distance #(.CORDIC_STAGES(STAGES)) uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .first_latitude(first_latitude), .first_longitude(first_longitude),
        .second_latitude(second_latitude), .second_longitude(second_longitude),
        .out_valid(out_valid), .out_stall(out_stall),
        .arc_distance(arc_distance)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        board = new();
        rst_n = 0;
        cfg_write = 0;
        cfg_data = '0;
        in_valid = 0;
        first_latitude = '0;
        first_longitude = '0;
        second_latitude = '0;
        second_longitude = '0;
    end

    // Watchdog. The slowest legal run is far below this bound.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: takes results, then picks the stall for the next cycle. The
    // stall density steps through a repeating set of levels, including quiet
    // stretches. Once, after several hundred requests, it holds off for a
    // long time so the pipeline fills and pushes back on the sender.
    int hold_left = 0;
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            board.check_distance(arc_distance);
        if (!hold_started && accepted >= 400)
        begin
            hold_started <= 1;
            hold_left = 3 * PIPE_DEPTH;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1;
        end
        else
        begin
            case ((cycle_count / 200) % 4)
                0: out_stall <= 0;
                1: out_stall <= ($urandom_range(0, 99) < 25);
                2: out_stall <= ($urandom_range(0, 99) < 70);
                default: out_stall <= ($urandom_range(0, 99) < 5);
            endcase
        end
    end

    // Present one request and hold it until the block takes it. Valid stays
    // high if the caller offers the next one straight away.
    task automatic send_request(input logic signed [23:0] lat_a,
                                input logic signed [24:0] lon_a,
                                input logic signed [23:0] lat_b,
                                input logic signed [24:0] lon_b);
        in_valid <= 1;
        first_latitude <= lat_a;
        first_longitude <= lon_a;
        second_latitude <= lat_b;
        second_longitude <= lon_b;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        board.note_request(first_latitude, first_longitude,
                           second_latitude, second_longitude);
        accepted++;
    endtask

    task automatic pause_sender(input int cycles);
        in_valid <= 0;
        repeat (cycles) @(posedge clk);
    endtask

    // Let every owed distance arrive, then let the pipeline settle.
    task automatic drain;
        in_valid <= 0;
        while (board.expected_dist.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
    endtask

    task automatic write_radius(input logic [12:0] km);
        drain();
        cfg_write <= 1;
        cfg_data <= km;
        @(posedge clk);
        cfg_write <= 0;
        board.radius_km = longint'(km);
    endtask

    // Coordinates: mostly inside the stated ranges, sometimes any field value.
    function automatic logic signed [23:0] pick_lat();
        if ($urandom_range(0, 9) == 0)
            return 24'($urandom());
        return 24'($urandom_range(0, 11796480) - 5898240);
    endfunction

    function automatic logic signed [24:0] pick_lon();
        if ($urandom_range(0, 9) == 0)
            return 25'($urandom());
        return 25'($urandom_range(0, 23592960) - 11796480);
    endfunction

    task automatic random_phase(input int count);
        int left;
        int burst;
        logic signed [23:0] la;
        logic signed [24:0] lo;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && left > 0)
            begin
                la = pick_lat();
                lo = pick_lon();
                case ($urandom_range(0, 3))
                    // Nearby points exercise the small-angle end.
                    0: send_request(la, lo,
                                    24'(la + $signed($urandom_range(0, 2000)) - 1000),
                                    25'(lo + $signed($urandom_range(0, 2000)) - 1000));
                    default: send_request(la, lo, pick_lat(), pick_lon());
                endcase
                burst--;
                left--;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 12));
        end
    endtask

    localparam logic signed [23:0] LAT_90  = 24'sd5898240;
    localparam logic signed [24:0] LON_180 = 25'sd11796480;
    localparam logic signed [23:0] LAT_0   = 24'sd0;
    localparam logic signed [24:0] LON_0   = 25'sd0;

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed requests at the reset radius: coincident points, poles,
        // antipodes, the dateline and the extremes of every field.
        send_request(LAT_0, LON_0, LAT_0, LON_0);
        send_request(LAT_90, LON_0, -LAT_90, LON_0);
        send_request(LAT_0, LON_0, LAT_0, LON_180);
        send_request(LAT_0, -LON_180, LAT_0, LON_180);
        send_request(LAT_90, -LON_180, LAT_90, LON_180);
        send_request(-LAT_90, LON_0, -LAT_90, LON_180);
        send_request(LAT_0, LON_0, LAT_0, 25'sd1);
        send_request(LAT_0, LON_0, 24'sd1, LON_0);
        send_request(24'sh7FFFFF, 25'sh0FFFFFF, 24'sh800000, 25'sh1000000);
        send_request(24'sh800000, 25'sh1000000, 24'sh7FFFFF, 25'sh0FFFFFF);
        send_request(24'sh7FFFFF, LON_0, 24'sh7FFFFF, 25'sh1000000);
        send_request(24'sd3342336, -25'sd8015872, -24'sd2228224, 25'sd9502720);
        send_request(LAT_90, LON_180, -LAT_90, -LON_180);
        send_request(-24'sd1, -25'sd1, 24'sd1, 25'sd1);
        pause_sender(3);

        // Largest radius: even the long distances stay below saturation.
        write_radius(13'd8191);
        send_request(LAT_0, LON_0, LAT_0, LON_180);
        send_request(LAT_90, LON_0, -LAT_90, LON_0);
        random_phase(450);

        write_radius(13'd1);
        random_phase(300);

        // Zero radius gives zero everywhere.
        write_radius(13'd0);
        send_request(LAT_0, LON_0, LAT_0, LON_180);
        random_phase(100);

        write_radius(13'd6371);
        random_phase(550);

        drain();
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
